### rtl/gtsm_pkg.sv
`default_nettype none
package gtsm_pkg;

  typedef enum logic [2:0] {
    REQ_ADD_STATE = 3'd0,
    REQ_ADD_TRANS = 3'd1,
    REQ_SET_CUR   = 3'd2,
    REQ_TRY       = 3'd3,
    REQ_TICK      = 3'd4
  } req_e;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_ARG = 3'd1;
  localparam logic [2:0] ST_KNOWN   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_FAILED  = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  localparam int GUARD_W = 16;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  state_id;
    logic [3:0]  source_id;
    logic        source_any;
    logic [31:0] timeout_limit;
    logic [15:0] guard_ok;
    logic [15:0] ms_passed;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        fired;
    logic [3:0]  prev_state;
    logic [3:0]  next_state;
    logic        have_current;
    logic [3:0]  now_state;
    logic [31:0] time_in_state;
  } rsp_t;

  // Classified command passed from the front part to the back part.
  typedef enum logic [1:0] {
    OP_DONE = 2'd0,
    OP_TRY  = 2'd1,
    OP_TICK = 2'd2
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  status;
    logic        set_cur;
    logic [3:0]  state_id;
    logic [15:0] guard_ok;
    logic [15:0] ms_passed;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SCAN = 2'd1,
    BK_DONE = 2'd2
  } bk_state_e;

endpackage
`default_nettype wire

### rtl/gtsm_front.sv
`default_nettype none
// Decodes requests, keeps the set of known states and appends table entries.
module gtsm_front #(
  parameter int NUM_STATES      = 16,
  parameter int MAX_TRANSITIONS = 16,
  parameter int IDX_W           = 4,
  parameter int CNT_W           = 5
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  input  wire gtsm_pkg::req_t        req,
  output logic                       cmd_valid,
  output gtsm_pkg::cmd_t             cmd,
  output logic                       wr_en,
  output logic [IDX_W-1:0]           wr_idx,
  output logic [CNT_W-1:0]           entry_count
);
  localparam int SID_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

  logic [NUM_STATES-1:0] known_states;
  logic                  in_range;
  logic                  known;
  gtsm_pkg::cmd_t        c;
  logic                  add_state;

  assign in_range = 32'(req.state_id) < 32'(NUM_STATES);
  assign known = in_range && known_states[SID_W'(req.state_id)];

  always_comb begin
    c = '0;
    c.op = gtsm_pkg::OP_DONE;
    c.status = gtsm_pkg::ST_OK;
    c.state_id = req.state_id;
    c.guard_ok = req.guard_ok;
    c.ms_passed = req.ms_passed;
    add_state = 1'b0;
    wr_en = 1'b0;
    unique case (req.req_type)
      gtsm_pkg::REQ_ADD_STATE: begin
        if (!in_range) c.status = gtsm_pkg::ST_BAD_ARG;
        else if (known) c.status = gtsm_pkg::ST_KNOWN;
        else add_state = in_valid;
      end
      gtsm_pkg::REQ_ADD_TRANS: begin
        if (!known) c.status = gtsm_pkg::ST_BAD_ARG;
        else if (32'(entry_count) >= 32'(MAX_TRANSITIONS)) c.status = gtsm_pkg::ST_FULL;
        else wr_en = in_valid;
      end
      gtsm_pkg::REQ_SET_CUR: begin
        if (!in_range) c.status = gtsm_pkg::ST_BAD_ARG;
        else if (!known) c.status = gtsm_pkg::ST_UNKNOWN;
        else c.set_cur = 1'b1;
      end
      gtsm_pkg::REQ_TRY: begin
        if (!in_range) c.status = gtsm_pkg::ST_BAD_ARG;
        else if (!known) c.status = gtsm_pkg::ST_UNKNOWN;
        else c.op = gtsm_pkg::OP_TRY;
      end
      gtsm_pkg::REQ_TICK: c.op = gtsm_pkg::OP_TICK;
      default: c.status = gtsm_pkg::ST_BAD_ARG;
    endcase
  end

  assign wr_idx = entry_count[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      known_states <= '0;
      entry_count <= '0;
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= in_valid;
      if (add_state) known_states[SID_W'(req.state_id)] <= 1'b1;
      if (wr_en) entry_count <= entry_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) cmd <= c;
  end
endmodule
`default_nettype wire

### rtl/gtsm_back.sv
`default_nettype none
// Holds the transition table and the current state; scans one entry a cycle.
module gtsm_back #(
  parameter int MAX_TRANSITIONS = 16,
  parameter int IDX_W           = 4,
  parameter int CNT_W           = 5
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cmd_valid,
  input  wire gtsm_pkg::cmd_t  cmd,
  input  wire                  wr_en,
  input  wire [IDX_W-1:0]      wr_idx,
  input  wire gtsm_pkg::req_t  wr_req,
  input  wire [CNT_W-1:0]      entry_count,
  output logic                 done,
  output gtsm_pkg::rsp_t       rsp
);
  logic [3:0]  t_src [MAX_TRANSITIONS];
  logic        t_any [MAX_TRANSITIONS];
  logic [3:0]  t_tgt [MAX_TRANSITIONS];
  logic [31:0] t_tmo [MAX_TRANSITIONS];

  gtsm_pkg::bk_state_e state, state_next;
  gtsm_pkg::cmd_t      cur_cmd;
  logic [CNT_W-1:0]    idx;
  logic [3:0]          current_id;
  logic                current_valid;
  logic [31:0]         elapsed_ms;
  logic [2:0]          res_status;
  logic                res_fired;
  logic [3:0]          res_prev, res_next;

  logic [IDX_W-1:0] ri;
  logic [3:0]  e_src, e_tgt;
  logic        e_any;
  logic [31:0] e_tmo;
  logic        src_ok, guard_pass, hit, last;
  logic [32:0] sum;

  assign ri = idx[IDX_W-1:0];
  assign e_src = t_src[ri];
  assign e_any = t_any[ri];
  assign e_tgt = t_tgt[ri];
  assign e_tmo = t_tmo[ri];
  assign src_ok = e_any || (current_valid && e_src == current_id);
  // Entries past the guard word have no guard bit and always pass.
  assign guard_pass = (32'(idx) >= gtsm_pkg::GUARD_W) ||
                      cur_cmd.guard_ok[4'(idx)];
  assign hit = (cur_cmd.op == gtsm_pkg::OP_TRY) ?
               (src_ok && e_tgt == cur_cmd.state_id && guard_pass) :
               (e_tmo != 32'd0 && src_ok && elapsed_ms >= e_tmo && guard_pass);
  assign last = 32'(idx) + 1 >= 32'(entry_count);
  assign sum = {1'b0, elapsed_ms} + 33'(cmd.ms_passed);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      t_src[wr_idx] <= wr_req.source_id;
      t_any[wr_idx] <= wr_req.source_any;
      t_tgt[wr_idx] <= wr_req.state_id;
      t_tmo[wr_idx] <= wr_req.timeout_limit;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gtsm_pkg::BK_IDLE: if (cmd_valid) begin
        if (cmd.op == gtsm_pkg::OP_DONE ||
            (cmd.op == gtsm_pkg::OP_TICK && !current_valid) || entry_count == '0)
          state_next = gtsm_pkg::BK_DONE;
        else state_next = gtsm_pkg::BK_SCAN;
      end
      gtsm_pkg::BK_SCAN: if (hit || last) state_next = gtsm_pkg::BK_DONE;
      gtsm_pkg::BK_DONE: state_next = gtsm_pkg::BK_IDLE;
      default: state_next = gtsm_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtsm_pkg::BK_IDLE;
      current_id <= '0;
      current_valid <= 1'b0;
      elapsed_ms <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == gtsm_pkg::BK_DONE);
      if (state == gtsm_pkg::BK_IDLE && cmd_valid) begin
        cur_cmd <= cmd;
        idx <= '0;
        res_status <= (cmd.op == gtsm_pkg::OP_TRY) ? gtsm_pkg::ST_FAILED : cmd.status;
        res_fired <= 1'b0;
        res_prev <= '0;
        res_next <= '0;
        if (cmd.set_cur) begin
          current_id <= cmd.state_id;
          current_valid <= 1'b1;
          elapsed_ms <= '0;
        end
        if (cmd.op == gtsm_pkg::OP_TICK && current_valid)
          elapsed_ms <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
      if (state == gtsm_pkg::BK_SCAN) begin
        idx <= idx + 1'b1;
        if (hit) begin
          res_fired <= 1'b1;
          res_status <= gtsm_pkg::ST_OK;
          res_prev <= current_valid ? current_id : 4'd0;
          res_next <= e_tgt;
          current_id <= e_tgt;
          current_valid <= 1'b1;
          elapsed_ms <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == gtsm_pkg::BK_DONE) begin
      rsp.status <= res_status;
      rsp.fired <= res_fired;
      rsp.prev_state <= res_prev;
      rsp.next_state <= res_next;
      rsp.have_current <= current_valid;
      rsp.now_state <= current_valid ? current_id : 4'd0;
      rsp.time_in_state <= elapsed_ms;
    end
  end
endmodule
`default_nettype wire

### rtl/guarded_timeout_state_machine.sv
`default_nettype none
// Table-driven state machine with guarded and timed transitions. A
// transaction is taken when start is high while busy is low; exactly one
// result follows, shown for one cycle with done high, and the receiver cannot
// stall it. A front part decodes the request, checks it against the known
// states and appends table entries; a one-deep command register hands the
// classified request to a back part, which scans the transition table one
// entry per cycle. A request goes through the command register, then, for a
// try or tick that scans, the scan state, which inspects the entries up to and
// including the first match (at most the entry count), then the done state;
// done is registered from the done state. busy stays high until the done
// cycle has ended, so a new transaction can be taken only after the previous
// result has been shown.
module guarded_timeout_state_machine #(
  parameter int NUM_STATES      = 16,
  parameter int MAX_TRANSITIONS = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire gtsm_pkg::req_t   req,
  output logic                  busy,
  output logic                  done,
  output gtsm_pkg::rsp_t        rsp
);
  localparam int IDX_W = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int CNT_W = $clog2(MAX_TRANSITIONS + 1);

  logic               accept;
  logic               cmd_valid;
  gtsm_pkg::cmd_t     cmd;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [CNT_W-1:0]   entry_count;
  logic               pending;

  assign accept = start && !busy;
  // The request is outstanding from acceptance until its done strobe.
  assign busy = pending;

  always_ff @(posedge clk) begin
    if (rst) pending <= 1'b0;
    else if (accept) pending <= 1'b1;
    else if (done) pending <= 1'b0;
  end

  gtsm_front #(
    .NUM_STATES(NUM_STATES), .MAX_TRANSITIONS(MAX_TRANSITIONS),
    .IDX_W(IDX_W), .CNT_W(CNT_W)
  ) u_front (
    .clk, .rst, .in_valid(accept), .req, .cmd_valid, .cmd,
    .wr_en, .wr_idx, .entry_count
  );

  gtsm_back #(
    .MAX_TRANSITIONS(MAX_TRANSITIONS), .IDX_W(IDX_W), .CNT_W(CNT_W)
  ) u_back (
    .clk, .rst, .cmd_valid, .cmd, .wr_en, .wr_idx, .wr_req(req),
    .entry_count, .done, .rsp
  );
endmodule
`default_nettype wire

### rtl/gtsm_checker.sv
`default_nettype none
module gtsm_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 start,
  input wire                 busy,
  input wire                 done,
  input wire gtsm_pkg::rsp_t rsp
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");
  a_done_only_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done without transaction");
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy held after done");
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    done && rsp.fired |-> rsp.status == gtsm_pkg::ST_OK && rsp.have_current &&
    rsp.now_state == rsp.next_state && rsp.time_in_state == 32'd0)
    else $error("fired result inconsistent");
endmodule

bind guarded_timeout_state_machine gtsm_checker u_chk (
  .clk, .rst, .start, .busy, .done, .rsp
);
`default_nettype wire
